### rtl/core/alarm_table_expiry_engine_defines.svh
// Assertion macros used by the alarm table expiry engine RTL.
`ifndef ALARM_TABLE_EXPIRY_ENGINE_DEFINES_SVH
`define ALARM_TABLE_EXPIRY_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ATE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ATE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ATE_ASSERT_IMP(label, ante, cons, msg)
`define ATE_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/ate_pkg.sv
// Types, codes and constants of the alarm table expiry engine.
package ate_pkg;

	localparam int DEF_ALARM_SLOTS = 8;
	localparam int MAX_EVENTS      = 8;
	localparam int CNT_W           = $clog2(MAX_EVENTS + 1);

	// Flag bit positions
	localparam int FLAG_PERIODIC  = 0;
	localparam int FLAG_TRIGGERED = 1;
	localparam int FLAG_EXPIRED   = 2;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_SET    = 3'd1,
		CMD_START  = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_ACK    = 3'd4,
		CMD_REMOVE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_NOT_USED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD,
		S_SCAN,
		S_FLUSH
	} state_t;

	// One slot entry as held in the table memory
	typedef struct packed {
		logic [2:0]  flags;
		logic [63:0] expiry;
		logic [31:0] period;
		logic [15:0] event_id;
	} slot_word_t;

	localparam int SLOT_W = $bits(slot_word_t);

endpackage

### rtl/core/ate_req_if.sv
// Request channel: one command or tick per transaction.
interface ate_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [2:0]  slot_index;
	logic [63:0] now_ms;
	logic [31:0] period_ms;
	logic        repeat_mode;
	logic [15:0] event_code;
	logic        create_new;
	logic        queue_ready;

	modport source (
		output valid, cmd, slot_index, now_ms, period_ms, repeat_mode, event_code,
			create_new, queue_ready,
		input  ready
	);

	modport sink (
		input  valid, cmd, slot_index, now_ms, period_ms, repeat_mode, event_code,
			create_new, queue_ready,
		output ready
	);
endinterface

### rtl/core/ate_rsp_if.sv
// Result channel: one status or fired event per transaction.
interface ate_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  fired_slot;
	logic [15:0] fired_event;
	logic [1:0]  status_code;
	logic        last;

	modport source (
		output valid, kind, fired_slot, fired_event, status_code, last,
		input  ready
	);

	modport sink (
		input  valid, kind, fired_slot, fired_event, status_code, last,
		output ready
	);
endinterface

### rtl/core/ate_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ate_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/core/alarm_table_expiry_engine.sv
// Alarm table expiry engine: command execution and tick scan over the slot memory.
//
//  channel | dir | transaction
//  --------+-----+-----------------------------------------------------------
//  req     | in  | tick or slot command (cmd, slot_index, now_ms, period_ms, ...)
//  rsp     | out | command status or fired alarm event, last marks end of item
//
// A command is accepted (memory read issued), then executes on the read data and
// writes back while the status enters the result register.
// A tick with queue_ready scans the table, reading one slot per cycle through the
// single read port of the slot memory unless a held result stalls the scan, then
// flushes the held event. A tick without queue_ready gives no result and stays idle.
// Reset clears the in-use bits at once; no clearing pass runs over the memory.
// A held result stalls a command in its execute cycle, and stalls the scan only
// when a second event needs the register.
`include "alarm_table_expiry_engine_defines.svh"

module alarm_table_expiry_engine #(
	parameter int ALARM_SLOTS = ate_pkg::DEF_ALARM_SLOTS
) (
	input  logic       clk,
	input  logic       arst_n,
	ate_req_if.sink    req,
	ate_rsp_if.source  rsp
);
	import ate_pkg::*;

	localparam int IW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ALARM_SLOTS - 1);
	localparam logic [6:0]    NSLOT    = 7'(ALARM_SLOTS);

	state_t state_q, state_d;

	// Captured request
	logic [2:0]  cmd_q;
	logic [2:0]  slot_q;
	logic [63:0] now_q;
	logic [31:0] period_q;
	logic        rep_q;
	logic [15:0] event_q;
	logic        create_q;

	// In-use bits and scan control
	logic [ALARM_SLOTS-1:0] used_q;
	logic [IW-1:0]          idx_s1, idx_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;

	// Event held until the next one shows whether it is the last
	logic        pend_valid_q, pend_valid_d;
	logic [2:0]  pend_slot_q;
	logic [15:0] pend_event_q;
	logic        pend_load;

	// Result register
	logic        out_valid_q;
	logic        out_kind_q, out_kind_d;
	logic [2:0]  out_slot_q, out_slot_d;
	logic [15:0] out_event_q, out_event_d;
	status_t     out_status_q, out_status_d;
	logic        out_last_q, out_last_d;
	logic        out_load, out_free;

	// Slot memory access
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	slot_word_t    rd_word, wr_word;
	logic [SLOT_W-1:0] ram_rdata;

	// Command execution
	logic        in_range, cmd_known, cur_used;
	logic [63:0] exp_sum;
	status_t     cmd_status;
	logic        used_wr, used_val;
	logic        due, stall, accept;

	ate_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (ALARM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_word   = slot_word_t'(ram_rdata);
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign in_range  = ({4'b0, slot_q} < NSLOT);
	assign cmd_known = (cmd_q inside {CMD_SET, CMD_START, CMD_STOP, CMD_ACK, CMD_REMOVE});
	assign cur_used  = used_q[IW'(slot_q)];
	assign exp_sum   = ((cmd_q == CMD_START) ? now_q : rd_word.expiry)
		+ {32'b0, rd_word.period};

	// Slot due on this tick
	assign due = used_q[idx_s1] && rd_word.flags[FLAG_TRIGGERED]
		&& !rd_word.flags[FLAG_EXPIRED] && (now_q >= rd_word.expiry)
		&& (cnt_q < CNT_W'(MAX_EVENTS));
	assign stall = due && pend_valid_q && !out_free;

	// Command decode to status and write-back word
	always_comb begin
		cmd_status = ST_OK;
		wr_word    = rd_word;
		used_wr    = 1'b0;
		used_val   = 1'b0;
		if (!cmd_known || !in_range) begin
			cmd_status = ST_INVALID;
		end else if (cmd_q == CMD_SET && create_q) begin
			if (period_q == 32'd0) begin
				cmd_status = ST_INVALID;
			end else begin
				used_wr          = 1'b1;
				used_val         = 1'b1;
				wr_word.flags    = {2'b00, rep_q};
				wr_word.expiry   = 64'd0;
				wr_word.period   = period_q;
				wr_word.event_id = event_q;
			end
		end else if (!cur_used) begin
			cmd_status = ST_NOT_USED;
		end else begin
			case (cmd_q)
				CMD_SET: begin
					if (period_q == 32'd0) begin
						cmd_status = ST_INVALID;
					end else begin
						wr_word.period                = period_q;
						wr_word.flags[FLAG_PERIODIC]  = rep_q;
					end
				end
				CMD_START: begin
					wr_word.flags[FLAG_TRIGGERED] = 1'b1;
					wr_word.flags[FLAG_EXPIRED]   = 1'b0;
					wr_word.expiry                = exp_sum;
				end
				CMD_STOP: begin
					wr_word.flags[FLAG_TRIGGERED] = 1'b0;
					wr_word.flags[FLAG_EXPIRED]   = 1'b1;
					wr_word.expiry                = 64'd0;
				end
				CMD_ACK: begin
					if (rd_word.flags == 3'b111) begin
						wr_word.expiry              = exp_sum;
						wr_word.flags[FLAG_EXPIRED] = 1'b0;
					end
				end
				default: begin
					// remove
					used_wr  = 1'b1;
					used_val = 1'b0;
				end
			endcase
		end
		// Firing on the tick scan
		if (state_q == S_SCAN) begin
			wr_word = rd_word;
			wr_word.flags[FLAG_EXPIRED] = 1'b1;
			wr_word.flags[FLAG_TRIGGERED] = rd_word.flags[FLAG_TRIGGERED]
				& rd_word.flags[FLAG_PERIODIC];
		end
	end

	// Next state, memory control and result loading
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_s1;
		cnt_d        = cnt_q;
		pend_valid_d = pend_valid_q;
		pend_load    = 1'b0;
		ram_re       = 1'b0;
		ram_raddr    = idx_s1 + IW'(1);
		ram_we       = 1'b0;
		ram_waddr    = idx_s1;
		out_load     = 1'b0;
		out_kind_d   = 1'b1;
		out_slot_d   = pend_slot_q;
		out_event_d  = pend_event_q;
		out_status_d = ST_OK;
		out_last_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					ram_re = 1'b1;
					if (req.cmd == CMD_TICK) begin
						ram_raddr = '0;
						idx_d     = '0;
						cnt_d     = '0;
						if (req.queue_ready) begin
							state_d = S_SCAN;
						end
					end else begin
						ram_raddr = IW'(req.slot_index);
						state_d   = S_CMD;
					end
				end
			end
			S_CMD: begin
				if (out_free) begin
					ram_we       = used_wr ? used_val : (cmd_status == ST_OK);
					ram_waddr    = IW'(slot_q);
					out_load     = 1'b1;
					out_kind_d   = 1'b0;
					out_slot_d   = slot_q;
					out_event_d  = 16'd0;
					out_status_d = cmd_status;
					out_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!stall) begin
					if (due) begin
						ram_we       = 1'b1;
						pend_load    = 1'b1;
						pend_valid_d = 1'b1;
						cnt_d        = cnt_q + CNT_W'(1);
						out_load     = pend_valid_q;
					end
					if (idx_s1 == LAST_IDX) begin
						state_d = S_FLUSH;
					end else begin
						idx_d  = idx_s1 + IW'(1);
						ram_re = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					out_load     = 1'b1;
					out_last_d   = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			idx_s1       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_s1       <= idx_d;
			cnt_q        <= cnt_d;
			pend_valid_q <= pend_valid_d;
			if (state_q == S_CMD && out_free && used_wr) begin
				used_q[IW'(slot_q)] <= used_val;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			slot_q   <= req.slot_index;
			now_q    <= req.now_ms;
			period_q <= req.period_ms;
			rep_q    <= req.repeat_mode;
			event_q  <= req.event_code;
			create_q <= req.create_new;
		end
		if (pend_load) begin
			pend_slot_q  <= 3'(idx_s1);
			pend_event_q <= rd_word.event_id;
		end
		if (out_load) begin
			out_kind_q   <= out_kind_d;
			out_slot_q   <= out_slot_d;
			out_event_q  <= out_event_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.fired_slot  = out_slot_q;
	assign rsp.fired_event = out_event_q;
	assign rsp.status_code = out_status_q;
	assign rsp.last        = out_last_q;

	`ATE_ASSERT_IMP(a_no_overwrite, out_load && out_valid_q, rsp.ready, "held result overwritten")
	`ATE_ASSERT_IMP(a_event_limit, state_q == S_SCAN, cnt_q <= CNT_W'(MAX_EVENTS), "too many events")
	`ATE_ASSERT_IMP(a_ram_collide, ram_we && ram_re, ram_waddr != ram_raddr, "slot read-write clash")
	`ATE_ASSERT_NXT(a_cmd_status, state_q == S_CMD && out_free, out_valid_q && !out_kind_q && out_last_q, "command status missing")
endmodule

### bench/alarm_table_expiry_engine_tb.sv
// Self-checking testbench for the alarm table expiry engine: directed table, then random traffic.
module alarm_table_expiry_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ate_pkg::*;

	localparam int          ALARM_SLOTS = DEF_ALARM_SLOTS;
	localparam int          CYCLE_LIMIT = 300000;
	localparam int          TOTAL_ITEMS = 350;
	localparam logic [2:0]  CMD_RSVD6   = 3'd6;
	localparam logic [2:0]  CMD_RSVD7   = 3'd7;
	localparam logic [63:0] NOW_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] PERIOD_MAX  = 32'hFFFF_FFFF;

	// One request transaction
	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  slot;
		logic [63:0] now;
		logic [31:0] period;
		logic        rep;
		logic [15:0] evt;
		logic        cnew;
		logic        qrdy;
	} alarm_req_t;

	// One result transaction
	typedef struct packed {
		logic        kind;
		logic [2:0]  slot;
		logic [15:0] evt;
		status_t     status;
		logic        last;
	} alarm_rsp_t;

	// How a directed row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_STATUS,
		CHK_SILENT
	} chk_t;

	typedef struct packed {
		alarm_req_t rq;
		chk_t       chk;
		status_t    st;
	} dir_row_t;

	localparam int DIR_ROWS = 25;

	// Directed rows: errors after reset, extremes, wrap, queue not ready, rearm
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{CMD_TICK,   3'd0, NOW_MAX, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b1}, CHK_SILENT, ST_OK},
		'{'{CMD_START,  3'd0, 64'd5,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b1}, CHK_STATUS, ST_NOT_USED},
		'{'{CMD_SET,    3'd1, 64'd0,   32'd9, 1'b1, 16'h0011, 1'b0, 1'b0}, CHK_STATUS, ST_NOT_USED},
		'{'{CMD_SET,    3'd2, 64'd0,   32'd0, 1'b0, 16'h0022, 1'b1, 1'b0}, CHK_STATUS, ST_INVALID},
		'{'{CMD_RSVD6,  3'd3, NOW_MAX, 32'd4, 1'b1, 16'hFFFF, 1'b1, 1'b1}, CHK_STATUS, ST_INVALID},
		'{'{CMD_RSVD7,  3'd7, 64'd0,   32'd4, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_INVALID},
		'{'{CMD_SET,    3'd0, 64'd0,   32'd1, 1'b0, 16'hFFFF, 1'b1, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_SET,    3'd7, 64'd0, PERIOD_MAX, 1'b1, 16'h0000, 1'b1, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_SET,    3'd3, 64'd0,   32'd5, 1'b1, 16'h1234, 1'b1, 1'b1}, CHK_STATUS, ST_OK},
		'{'{CMD_START,  3'd0, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_START,  3'd7, NOW_MAX, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_START,  3'd3, 64'd100, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_TICK,   3'd0, 64'd104, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b1}, CHK_MODEL,  ST_OK},
		'{'{CMD_TICK,   3'd0, 64'd200, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_SILENT, ST_OK},
		'{'{CMD_TICK,   3'd0, 64'd200, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b1}, CHK_MODEL,  ST_OK},
		'{'{CMD_ACK,    3'd3, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_MODEL,  ST_OK},
		'{'{CMD_TICK,   3'd0, 64'd110, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b1}, CHK_MODEL,  ST_OK},
		'{'{CMD_SET,    3'd3, 64'd0,   32'd0, 1'b1, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_INVALID},
		'{'{CMD_SET,    3'd3, 64'd0,   32'd7, 1'b0, 16'hBEEF, 1'b0, 1'b0}, CHK_MODEL,  ST_OK},
		'{'{CMD_ACK,    3'd0, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_STOP,   3'd3, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_TICK,   3'd0, NOW_MAX, 32'd0, 1'b0, 16'h0000, 1'b0, 1'b1}, CHK_MODEL,  ST_OK},
		'{'{CMD_REMOVE, 3'd7, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_OK},
		'{'{CMD_REMOVE, 3'd7, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_NOT_USED},
		'{'{CMD_ACK,    3'd5, 64'd0,   32'd0, 1'b0, 16'h0000, 1'b0, 1'b0}, CHK_STATUS, ST_NOT_USED}
	};

	logic clk = 1'b0;
	logic arst_n;

	ate_req_if req_ch ();
	ate_rsp_if rsp_ch ();

	alarm_table_expiry_engine #(
		.ALARM_SLOTS(ALARM_SLOTS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	// Predicted alarm table
	logic        tbl_used   [ALARM_SLOTS];
	logic [2:0]  tbl_flags  [ALARM_SLOTS];
	logic [63:0] tbl_expiry [ALARM_SLOTS];
	logic [31:0] tbl_period [ALARM_SLOTS];
	logic [15:0] tbl_event  [ALARM_SLOTS];

	alarm_rsp_t  step_rsp    [$];
	alarm_rsp_t  pending_rsp [$];

	logic [63:0] now_t;
	int          idle_pct    = 11;
	int          hold_req    = 0;
	int          hold_left   = 0;
	int          cycles      = 0;
	int          mismatches  = 0;
	int          n_ticks     = 0;
	int          n_cmds      = 0;
	int          n_status    = 0;
	int          n_events    = 0;

	// Table update and expected results for one accepted transaction
	function automatic void predict_alarm(alarm_req_t r);
		int          n = 0;
		status_t     st;
		logic [2:0]  s;
		step_rsp.delete();
		s = r.slot;
		if (r.cmd == CMD_TICK) begin
			if (r.qrdy) begin
				for (int i = 0; i < ALARM_SLOTS && n < MAX_EVENTS; i++) begin
					if (tbl_used[i] && tbl_flags[i][FLAG_TRIGGERED] &&
							!tbl_flags[i][FLAG_EXPIRED] && r.now >= tbl_expiry[i]) begin
						step_rsp.push_back('{1'b1, 3'(i), tbl_event[i], ST_OK, 1'b0});
						n++;
						tbl_flags[i][FLAG_EXPIRED] = 1'b1;
						if (!tbl_flags[i][FLAG_PERIODIC])
							tbl_flags[i][FLAG_TRIGGERED] = 1'b0;
					end
				end
				if (n > 0)
					step_rsp[n - 1].last = 1'b1;
			end
			return;
		end
		if (r.cmd > CMD_REMOVE || int'(s) >= ALARM_SLOTS) begin
			st = ST_INVALID;
		end else if (r.cmd == CMD_SET && r.cnew) begin
			// create resets the slot
			if (r.period == 32'd0) begin
				st = ST_INVALID;
			end else begin
				st            = ST_OK;
				tbl_used[s]   = 1'b1;
				tbl_flags[s]  = 3'b000;
				tbl_flags[s][FLAG_PERIODIC] = r.rep;
				tbl_expiry[s] = 64'd0;
				tbl_period[s] = r.period;
				tbl_event[s]  = r.evt;
			end
		end else if (!tbl_used[s]) begin
			st = ST_NOT_USED;
		end else begin
			st = ST_OK;
			case (r.cmd)
				CMD_SET: begin
					if (r.period == 32'd0) begin
						st = ST_INVALID;
					end else begin
						tbl_period[s] = r.period;
						tbl_flags[s][FLAG_PERIODIC] = r.rep;
					end
				end
				CMD_START: begin
					tbl_flags[s][FLAG_TRIGGERED] = 1'b1;
					tbl_flags[s][FLAG_EXPIRED]   = 1'b0;
					tbl_expiry[s] = r.now + 64'(tbl_period[s]);
				end
				CMD_STOP: begin
					tbl_flags[s][FLAG_TRIGGERED] = 1'b0;
					tbl_flags[s][FLAG_EXPIRED]   = 1'b1;
					tbl_expiry[s] = 64'd0;
				end
				CMD_ACK: begin
					// rearm only a fired periodic alarm
					if (tbl_flags[s] == 3'b111) begin
						tbl_expiry[s] = tbl_expiry[s] + 64'(tbl_period[s]);
						tbl_flags[s][FLAG_EXPIRED] = 1'b0;
					end
				end
				default: begin
					tbl_used[s]   = 1'b0;
					tbl_flags[s]  = 3'b000;
					tbl_expiry[s] = 64'd0;
				end
			endcase
		end
		step_rsp.push_back('{1'b0, s, 16'h0000, st, 1'b1});
	endfunction

	function automatic logic [31:0] pick_period();
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return 32'($urandom_range(1, 30));
		else if (p < 85)
			return 32'($urandom_range(1, 1000));
		else if (p < 95)
			return $urandom;
		return PERIOD_MAX;
	endfunction

	// Random request, mostly well-formed alarm traffic around a running time base
	function automatic alarm_req_t next_request();
		alarm_req_t r;
		int         pick;
		r.slot   = 3'($urandom_range(7));
		r.now    = {$urandom, $urandom};
		r.period = $urandom;
		r.rep    = 1'($urandom_range(1));
		r.evt    = 16'($urandom_range(16'hFFFF));
		r.cnew   = 1'($urandom_range(1));
		r.qrdy   = ($urandom_range(99) < 85);
		pick     = $urandom_range(99);
		if (pick < 30) begin
			r.cmd = CMD_TICK;
			now_t = now_t + 64'($urandom_range(40));
			if ($urandom_range(99) < 2)
				now_t = {$urandom, $urandom};
			else if ($urandom_range(99) < 1)
				now_t = NOW_MAX - 64'($urandom_range(100));
			if ($urandom_range(99) >= 5)
				r.now = now_t;
		end else if (pick < 45) begin
			r.cmd    = CMD_SET;
			r.cnew   = 1'b1;
			r.period = pick_period();
		end else if (pick < 52) begin
			r.cmd    = CMD_SET;
			r.cnew   = 1'b0;
			r.period = pick_period();
		end else if (pick < 67) begin
			r.cmd = CMD_START;
			if ($urandom_range(99) < 90)
				r.now = now_t;
		end else if (pick < 79) begin
			r.cmd = CMD_ACK;
		end else if (pick < 85) begin
			r.cmd = CMD_STOP;
		end else if (pick < 91) begin
			r.cmd = CMD_REMOVE;
		end else if (pick < 96) begin
			r.cmd = $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
		end else begin
			r.cmd    = CMD_SET;
			r.period = 32'd0;
		end
		return r;
	endfunction

	// Offer one transaction; called and returns at a falling edge
	task automatic offer_request(alarm_req_t r, chk_t chk, status_t st);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.cmd         <= r.cmd;
		req_ch.slot_index  <= r.slot;
		req_ch.now_ms      <= r.now;
		req_ch.period_ms   <= r.period;
		req_ch.repeat_mode <= r.rep;
		req_ch.event_code  <= r.evt;
		req_ch.create_new  <= r.cnew;
		req_ch.queue_ready <= r.qrdy;
		req_ch.valid       <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		predict_alarm(r);
		if (r.cmd == CMD_TICK)
			n_ticks++;
		else
			n_cmds++;
		case (chk)
			CHK_MODEL:  foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
			CHK_STATUS: pending_rsp.push_back('{1'b0, r.slot, 16'h0000, st, 1'b1});
			default:    ;
		endcase
		@(negedge clk);
	endtask

	// Fill every slot, start them all, then one tick makes them all due
	task automatic fill_table_burst();
		alarm_req_t r;
		for (int s = 0; s < ALARM_SLOTS; s++) begin
			r        = next_request();
			r.cmd    = CMD_SET;
			r.slot   = 3'(s);
			r.cnew   = 1'b1;
			r.period = 32'($urandom_range(1, 1000));
			offer_request(r, CHK_MODEL, ST_OK);
		end
		for (int s = 0; s < ALARM_SLOTS; s++) begin
			r      = next_request();
			r.cmd  = CMD_START;
			r.slot = 3'(s);
			r.now  = now_t;
			offer_request(r, CHK_MODEL, ST_OK);
		end
		now_t  = now_t + 64'd2000;
		r      = next_request();
		r.cmd  = CMD_TICK;
		r.now  = now_t;
		r.qrdy = 1'b1;
		offer_request(r, CHK_MODEL, ST_OK);
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Result receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		alarm_rsp_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_ch.kind)
				n_events++;
			else
				n_status++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d event 0x%0h status %0d",
					rsp_ch.kind, rsp_ch.fired_slot, rsp_ch.fired_event, rsp_ch.status_code);
				mismatches++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				check_field("kind",        16'(exp_rsp.kind),   16'(rsp_ch.kind));
				check_field("fired_slot",  16'(exp_rsp.slot),   16'(rsp_ch.fired_slot));
				check_field("fired_event", exp_rsp.evt,         rsp_ch.fired_event);
				check_field("status_code", 16'(exp_rsp.status), 16'(rsp_ch.status_code));
				check_field("last",        16'(exp_rsp.last),   16'(rsp_ch.last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_rsp.size());
			$display("** alarm_table_expiry_engine: FAILED **");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int rand_items;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_TICK;
		req_ch.slot_index  = 3'd0;
		req_ch.now_ms      = 64'd0;
		req_ch.period_ms   = 32'd0;
		req_ch.repeat_mode = 1'b0;
		req_ch.event_code  = 16'h0000;
		req_ch.create_new  = 1'b0;
		req_ch.queue_ready = 1'b0;
		now_t              = 64'd0;
		for (int i = 0; i < ALARM_SLOTS; i++) begin
			tbl_used[i]   = 1'b0;
			tbl_flags[i]  = 3'b000;
			tbl_expiry[i] = 64'd0;
			tbl_period[i] = 32'd0;
			tbl_event[i]  = 16'h0000;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_rows[i])
			offer_request(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].st);

		// random traffic with full-table bursts, a stretch without idles and one long hold-off
		rand_items = 0;
		while (n_ticks + n_cmds < TOTAL_ITEMS) begin
			if (rand_items == 140)
				hold_req = 250;
			if (rand_items % 70 == 0)
				fill_table_burst();
			idle_pct = (rand_items >= 180 && rand_items < 250) ? 0 : 11;
			offer_request(next_request(), CHK_MODEL, ST_OK);
			rand_items++;
		end
		req_ch.valid <= 1'b0;
		idle_pct = 11;

		// drain, then allow one full scan for stray results
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4 * ALARM_SLOTS + 8) @(posedge clk);

		$display("Run: %0d requests (%0d ticks, %0d commands) in %0d cycles",
			n_ticks + n_cmds, n_ticks, n_cmds, cycles);
		$display("Checked %0d status and %0d alarm event results, %0d mismatches",
			n_status, n_events, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("** alarm_table_expiry_engine: PASSED **");
		end else begin
			$display("** alarm_table_expiry_engine: FAILED **");
		end
		$finish;
	end

endmodule
